[hw/rtl/vtab_pkg.sv]
// Shared constants, codes and types of the value table block.
// Used by every module of the block; depends on nothing.
package vtab_pkg;

	localparam int DEPTH      = 16;
	localparam int MAX_OUT    = 16;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int DATA_W     = 32;
	localparam int OP_W       = 2;
	localparam int STAT_W     = 3;
	localparam int POS_W      = 4;
	localparam int FILL_W     = 5;
	localparam int S_TDATA_W  = 64;
	localparam int M_TDATA_W  = 48;
	localparam int M_FIELDS_W = DATA_W + POS_W + FILL_W;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;
	localparam logic [OP_W-1:0] OP_READ   = 2'd3;

	localparam logic [STAT_W-1:0] ST_DONE      = 3'd0;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STAT_W-1:0] ST_READ      = 3'd3;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [DATA_W-1:0] data;
		logic [POS_W-1:0]  position;
		logic [FILL_W-1:0] fill;
		logic              last;
	} res_t;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [DATA_W-1:0] wdata;
		logic [IDX_W-1:0]  raddr;
	} mem_req_t;

	function automatic res_t mk_res(input logic [STAT_W-1:0] status,
		input logic [DATA_W-1:0] data, input logic [POS_W-1:0] position,
		input logic [FILL_W-1:0] fill, input logic last);
		res_t r;
		r.status   = status;
		r.data     = data;
		r.position = position;
		r.fill     = fill;
		r.last     = last;
		return r;
	endfunction

endpackage

[hw/rtl/vtab_store.sv]
// Entry memory of the value table: one write and one registered read per cycle.
// Depends on vtab_pkg.
module vtab_store (
	input  logic                         clk,
	input  vtab_pkg::mem_req_t           req,
	output logic [vtab_pkg::DATA_W-1:0]  rd_data
);
	import vtab_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rd_data_q <= mem_q[req.raddr];
	end

	assign rd_data = rd_data_q;

endmodule

[hw/rtl/vtab_ctrl.sv]
// Command sequencer of the value table: search, shift, update and read-out over the memory.
// Holds the entry count; depends on vtab_pkg.
module vtab_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [vtab_pkg::OP_W-1:0]    in_op,
	input  logic [vtab_pkg::DATA_W-1:0]  in_value,
	input  logic [vtab_pkg::DATA_W-1:0]  in_new_value,
	output vtab_pkg::mem_req_t           mem_req,
	input  logic [vtab_pkg::DATA_W-1:0]  rd_data,
	output logic                         res_valid,
	output vtab_pkg::res_t               res,
	input  logic                         res_ready
);
	import vtab_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SCAN     = 3'd1;
	localparam logic [2:0] S_SHIFT    = 3'd2;
	localparam logic [2:0] S_EMIT     = 3'd3;
	localparam logic [2:0] S_RD_ISSUE = 3'd4;
	localparam logic [2:0] S_RD_WAIT  = 3'd5;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  ptr_q;
	logic              rv_s1;
	logic [IDX_W-1:0]  ridx_s1;
	logic [OP_W-1:0]   op_q;
	logic [DATA_W-1:0] key_q;
	logic [DATA_W-1:0] nval_q;
	logic [IDX_W-1:0]  pos_q;
	res_t              res_q;

	logic accept;
	logic issue;
	logic hit;
	logic last_chk;
	logic full;
	logic rd_last;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign issue    = ((state_q == S_SCAN) || (state_q == S_SHIFT)) && (ptr_q < count_q);
	assign hit      = rv_s1 && (rd_data == key_q);
	assign last_chk = rv_s1 && ((CNT_W'(ridx_s1) + CNT_W'(1)) == count_q);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign rd_last  = ((ptr_q + CNT_W'(1)) == count_q)
		|| ((ptr_q + CNT_W'(1)) == CNT_W'(MAX_OUT));

	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.waddr = ridx_s1;
		mem_req.wdata = rd_data;
		mem_req.raddr = ptr_q[IDX_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (accept && (in_op == OP_INSERT) && !full) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = count_q[IDX_W-1:0];
					mem_req.wdata = in_value;
				end
			end
			S_SCAN: begin
				if (hit && (op_q == OP_UPDATE)) begin
					mem_req.we    = 1'b1;
					mem_req.wdata = nval_q;
				end
			end
			S_SHIFT: begin
				if (rv_s1) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = ridx_s1 - IDX_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign res_valid = (state_q == S_EMIT) || (state_q == S_RD_WAIT);
	assign res = (state_q == S_RD_WAIT)
		? mk_res(ST_READ, rd_data, POS_W'(ptr_q), FILL_W'(count_q), rd_last)
		: res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ptr_q   <= '0;
			rv_s1   <= 1'b0;
			ridx_s1 <= '0;
			op_q    <= OP_INSERT;
			key_q   <= '0;
			nval_q  <= '0;
			pos_q   <= '0;
			res_q   <= '0;
		end else begin
			rv_s1 <= issue;
			if (issue) begin
				ptr_q   <= ptr_q + CNT_W'(1);
				ridx_s1 <= ptr_q[IDX_W-1:0];
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q   <= in_op;
						key_q  <= in_value;
						nval_q <= in_new_value;
						ptr_q  <= '0;
						unique case (in_op)
							OP_INSERT: begin
								if (!full) begin
									res_q <= mk_res(ST_DONE, in_value, POS_W'(count_q),
										FILL_W'(count_q + CNT_W'(1)), 1'b1);
									count_q <= count_q + CNT_W'(1);
								end else begin
									res_q <= mk_res(ST_FULL, in_value, '0, FILL_W'(count_q), 1'b1);
								end
								state_q <= S_EMIT;
							end
							OP_DELETE, OP_UPDATE: begin
								if (count_q == '0) begin
									res_q <= mk_res(ST_NOT_FOUND, in_value, '0, '0, 1'b1);
									state_q <= S_EMIT;
								end else begin
									state_q <= S_SCAN;
								end
							end
							OP_READ: begin
								if (count_q == '0) begin
									res_q <= mk_res(ST_EMPTY, '0, '0, '0, 1'b1);
									state_q <= S_EMIT;
								end else begin
									state_q <= S_RD_ISSUE;
								end
							end
						endcase
					end
				end
				S_SCAN: begin
					if (hit) begin
						if (op_q == OP_UPDATE) begin
							res_q <= mk_res(ST_DONE, nval_q, POS_W'(ridx_s1),
								FILL_W'(count_q), 1'b1);
							state_q <= S_EMIT;
						end else begin
							pos_q   <= ridx_s1;
							state_q <= S_SHIFT;
						end
					end else if (last_chk) begin
						res_q <= mk_res(ST_NOT_FOUND, key_q, '0, FILL_W'(count_q), 1'b1);
						state_q <= S_EMIT;
					end
				end
				S_SHIFT: begin
					if (!issue && !rv_s1) begin
						count_q <= count_q - CNT_W'(1);
						res_q <= mk_res(ST_DONE, key_q, POS_W'(pos_q),
							FILL_W'(count_q - CNT_W'(1)), 1'b1);
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				S_RD_ISSUE: begin
					state_q <= S_RD_WAIT;
				end
				S_RD_WAIT: begin
					if (res_ready) begin
						ptr_q   <= ptr_q + CNT_W'(1);
						state_q <= rd_last ? S_IDLE : S_RD_ISSUE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[hw/rtl/vtab_obuf.sv]
// Output register of the value table: holds one result until the sink takes it.
// Depends on vtab_pkg.
module vtab_obuf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            res_valid,
	input  vtab_pkg::res_t  res,
	output logic            res_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output vtab_pkg::res_t  out_res
);
	import vtab_pkg::*;

	logic valid_q;
	res_t res_q;

	assign res_ready = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

endmodule

[hw/rtl/value_table_insert_delete_update_top.sv]
// Value table top level. The insert result is registered in the sequencer, then in the output
// register; delete and update scan the memory one entry per cycle, and delete then moves
// each later entry down one place per cycle. Read fetches each entry by a registered memory
// read, holding each result until it is taken. One command is worked on at a time. Reset
// clears the entry count and the control state; the entry memory itself is not cleared.
module value_table_insert_delete_update_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [vtab_pkg::S_TDATA_W-1:0]    s_tdata,  // value, new_value
	input  logic [vtab_pkg::OP_W-1:0]         s_tuser,  // op
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [vtab_pkg::M_TDATA_W-1:0]    m_tdata,  // data, position, fill, zero pad
	output logic [vtab_pkg::STAT_W-1:0]       m_tuser,  // status
	output logic                              m_tlast
);
	import vtab_pkg::*;

	mem_req_t          mem_req;
	logic [DATA_W-1:0] rd_data;
	logic              res_valid;
	logic              res_ready;
	res_t              res;
	res_t              out_res;

	vtab_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_op        (s_tuser),
		.in_value     (s_tdata[DATA_W-1:0]),
		.in_new_value (s_tdata[2*DATA_W-1:DATA_W]),
		.mem_req      (mem_req),
		.rd_data      (rd_data),
		.res_valid    (res_valid),
		.res          (res),
		.res_ready    (res_ready)
	);

	vtab_store u_store (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	vtab_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {{(M_TDATA_W - M_FIELDS_W){1'b0}}, out_res.fill, out_res.position,
		out_res.data};
	assign m_tuser = out_res.status;
	assign m_tlast = out_res.last;

endmodule

[hw/rtl/vtab_chk.sv]
// Port-level checks of the value table top level, attached by the bind below.
// Depends on vtab_pkg and value_table_insert_delete_update_top.
module vtab_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [vtab_pkg::S_TDATA_W-1:0]    s_tdata,
	input logic [vtab_pkg::OP_W-1:0]         s_tuser,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [vtab_pkg::M_TDATA_W-1:0]    m_tdata,
	input logic [vtab_pkg::STAT_W-1:0]       m_tuser,
	input logic                              m_tlast
);
	import vtab_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second command taken while one is in progress");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_READ) |-> m_tlast)
		else $error("single result without last");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[DATA_W+POS_W +: FILL_W] <= FILL_W'(DEPTH)))
		else $error("fill beyond table depth");

	a_empty_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_EMPTY) |-> (m_tdata[DATA_W+POS_W +: FILL_W] == '0))
		else $error("empty result with nonzero fill");

endmodule

bind value_table_insert_delete_update_top vtab_chk u_vtab_chk (.*);
